// File: rtl/p7d_pkg.sv
// Package with the request and result types, state type and constants of the patch dump decoder.
`timescale 1ns / 1ps
`default_nettype none

package p7d_pkg;

    localparam logic [8:0] PAYLOAD_LEN  = 9'd432;
    localparam logic [8:0] COUNT_SAT    = 9'd433;
    localparam logic [8:0] TAG_FIRST    = 9'd7;
    localparam logic [8:0] STORED_FIRST = 9'd15;
    localparam logic [8:0] SIZE_FIRST   = 9'd51;
    localparam logic [8:0] SUM_FIRST    = 9'd63;
    localparam logic [8:0] SUM_END      = 9'd375;
    localparam logic [7:0] MAKER_HI     = 8'h0E;
    localparam logic [7:0] PRODUCT_ID   = 8'h22;

    localparam int F_STATUS  = 0;
    localparam int F_MAKER   = 1;
    localparam int F_PRODUCT = 2;
    localparam int F_TAG     = 3;
    localparam int F_SIZE    = 4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_LENGTH  = 3'd1;
    localparam logic [2:0] ST_STATBIT = 3'd2;
    localparam logic [2:0] ST_MAKER   = 3'd3;
    localparam logic [2:0] ST_PRODUCT = 3'd4;
    localparam logic [2:0] ST_TAG     = 3'd5;
    localparam logic [2:0] ST_SIZE    = 3'd6;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  decoded_byte;
        logic        done_res;
        logic [2:0]  status;
        logic        checksum_ok;
        logic [7:0]  bank;
        logic        multiple;
        logic [7:0]  slot;
        logic [31:0] file_checksum;
        logic [31:0] computed_checksum;
    } out_t;

    typedef struct packed {
        logic [8:0]  byte_count;
        logic [6:0]  prefix_bits;
        logic [4:0]  fault_flags;
        logic [31:0] word_sum;
        logic [31:0] stored_word;
        logic [7:0]  bank_byte;
        logic        multiple_flag;
        logic [7:0]  slot_byte;
    } state_t;

    function automatic logic [7:0] tag_byte(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = 8'h51;
            3'd1: r = 8'h30;
            3'd2: r = 8'h31;
            3'd3: r = 8'h53;
            3'd4: r = 8'h59;
            3'd5: r = 8'h4E;
            3'd6: r = 8'h54;
            default: r = 8'h48;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] size_byte(input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0: r = 8'h00;
            2'd1: r = 8'h00;
            2'd2: r = 8'h01;
            default: r = 8'h3B;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/p7d_step.sv
// Next-state and result logic for one payload byte of the patch dump decoder.
`timescale 1ns / 1ps
`default_nettype none

module p7d_step (
    input  wire p7d_pkg::state_t st,
    input  wire p7d_pkg::in_t    din,
    output p7d_pkg::state_t      st_next,
    output p7d_pkg::out_t        res,
    output logic                 produce
);
    import p7d_pkg::*;

    logic [8:0]  idx;
    logic [2:0]  pos;
    logic [8:0]  grp;
    logic [8:0]  d;
    logic [8:0]  off;
    logic [7:0]  prefix8;
    logic        msb;
    logic        in_range;
    logic        valid;
    logic [7:0]  dec;
    logic [31:0] addend;
    logic [2:0]  st_code;
    logic [31:0] expect_sum;
    state_t      upd;

    always_comb
    begin
        idx      = st.byte_count;
        pos      = idx[2:0];
        grp      = {3'b000, idx[8:3]};
        d        = (grp << 3) - grp + {6'd0, pos} - 9'd1;
        off      = d - SUM_FIRST;
        prefix8  = {1'b0, st.prefix_bits};
        msb      = prefix8[3'd7 - pos];
        in_range = idx < PAYLOAD_LEN;
        valid    = in_range && (pos != 3'd0);
        dec      = valid ? {msb, din.payload_byte[6:0]} : 8'd0;
        upd      = st;

        if (in_range && din.payload_byte[7])
        begin
            upd.fault_flags[F_STATUS] = 1'b1;
        end
        if (in_range && pos == 3'd0)
        begin
            upd.prefix_bits = din.payload_byte[6:0];
        end

        unique case (off[1:0])
            2'd0: addend = {dec, 24'd0};
            2'd1: addend = {8'd0, dec, 16'd0};
            2'd2: addend = {16'd0, dec, 8'd0};
            default: addend = {24'd0, dec};
        endcase

        if (valid)
        begin
            if (d == 9'd0 && dec != 8'h00)
            begin
                upd.fault_flags[F_MAKER] = 1'b1;
            end
            if (d == 9'd1 && dec != MAKER_HI)
            begin
                upd.fault_flags[F_MAKER] = 1'b1;
            end
            if (d == 9'd2 && dec != PRODUCT_ID)
            begin
                upd.fault_flags[F_PRODUCT] = 1'b1;
            end
            if (d == 9'd4)
            begin
                upd.bank_byte = dec;
            end
            if (d == 9'd5)
            begin
                upd.multiple_flag = (dec != 8'd0);
            end
            if (d == 9'd6)
            begin
                upd.slot_byte = dec;
            end
            if (d >= TAG_FIRST && d < STORED_FIRST
                && dec != tag_byte(3'(d - TAG_FIRST)))
            begin
                upd.fault_flags[F_TAG] = 1'b1;
            end
            if (d >= STORED_FIRST && d < STORED_FIRST + 9'd4)
            begin
                upd.stored_word = {st.stored_word[23:0], dec};
            end
            if (d >= SIZE_FIRST && d < SIZE_FIRST + 9'd4
                && dec != size_byte(2'(d - SIZE_FIRST)))
            begin
                upd.fault_flags[F_SIZE] = 1'b1;
            end
            if (d >= SUM_FIRST && d < SUM_END)
            begin
                upd.word_sum = st.word_sum + addend;
            end
        end

        if (idx < COUNT_SAT)
        begin
            upd.byte_count = idx + 9'd1;
        end

        priority if (upd.byte_count != PAYLOAD_LEN)
            st_code = ST_LENGTH;
        else if (upd.fault_flags[F_STATUS])
            st_code = ST_STATBIT;
        else if (upd.fault_flags[F_MAKER])
            st_code = ST_MAKER;
        else if (upd.fault_flags[F_PRODUCT])
            st_code = ST_PRODUCT;
        else if (upd.fault_flags[F_TAG])
            st_code = ST_TAG;
        else if (upd.fault_flags[F_SIZE])
            st_code = ST_SIZE;
        else
            st_code = ST_OK;

        expect_sum = 32'd0 - upd.word_sum;

        res                   = '0;
        res.data_valid        = valid;
        res.decoded_byte      = dec;
        if (din.end_of_message)
        begin
            res.done_res = 1'b1;
            res.status   = st_code;
            if (st_code == ST_OK)
            begin
                res.checksum_ok       = (upd.stored_word == expect_sum);
                res.bank              = upd.bank_byte;
                res.multiple          = upd.multiple_flag;
                res.slot              = upd.slot_byte;
                res.file_checksum     = upd.stored_word;
                res.computed_checksum = expect_sum;
            end
        end

        produce = valid || din.end_of_message;
        st_next = din.end_of_message ? '0 : upd;
    end

endmodule

`default_nettype wire

// File: rtl/patch_dump_7in8_decoder_checker_top.sv
// Top level of the patch dump 7-in-8 decoder and checker.
// An accepted request reaches its result through the input register and the result register.
// Throughput: one request per cycle while the result side does not stall; the state update
// of each byte is a single pass.
// Reset clears the handshake registers and all message state at once.
`timescale 1ns / 1ps
`default_nettype none

module patch_dump_7in8_decoder_checker_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    output logic               byte_stall,
    input  wire p7d_pkg::in_t  byte_data,
    output logic               res_valid,
    input  wire logic          res_stall,
    output p7d_pkg::out_t      res_data
);
    import p7d_pkg::*;

    logic   in_valid_reg;
    logic   in_valid_next;
    in_t    in_data_reg;
    logic   res_valid_reg;
    logic   res_valid_next;
    out_t   res_data_reg;
    state_t state_reg;
    state_t state_next;
    out_t   step_res;
    logic   step_produce;
    logic   stage_stall;
    logic   advance;
    logic   accept;

    p7d_step u_step (
        .st      (state_reg),
        .din     (in_data_reg),
        .st_next (state_next),
        .res     (step_res),
        .produce (step_produce)
    );

    always_comb
    begin
        stage_stall    = res_valid_reg && res_stall;
        advance        = in_valid_reg && !stage_stall;
        byte_stall     = in_valid_reg && stage_stall;
        accept         = byte_valid && !byte_stall;
        in_valid_next  = accept || (in_valid_reg && !advance);
        res_valid_next = advance ? step_produce : stage_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= byte_data;
        end
        if (advance && step_produce)
        begin
            res_data_reg <= step_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the patch dump 7-in-8 decoder and checker.
`timescale 1ns / 1ps

module tb;

    import p7d_pkg::*;

    localparam logic [63:0] TAG_TEXT    = "Q01SYNTH";
    localparam logic [31:0] SIZE_WORD   = 32'd315;
    localparam int          PATCH_BYTES = 378;
    localparam int          SUM_WORDS   = 78;
    localparam int          HOLD_CYCLES = 300;
    localparam int          MAX_REPORTS = 100;

    typedef enum int {
        FAULT_NONE,
        FAULT_SUM,
        FAULT_STATBIT,
        FAULT_MAKER,
        FAULT_PRODUCT,
        FAULT_TAG,
        FAULT_SIZE,
        FAULT_LONG,
        FAULT_SHORT
    } fault_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_stall;
    in_t  byte_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    out_t res_data;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    logic hold_off = 1'b0;
    event hold_start;

    out_t expected_results[$];
    logic [7:0] patch_image[PATCH_BYTES];
    logic [7:0] wire_bytes[$];

    int         msg_count = 0;
    logic [6:0] prefix_msbs = '0;
    logic [4:0] fault_seen = '0;
    logic [31:0] sum_acc = '0;
    logic [31:0] stored_acc = '0;
    logic [7:0] bank_cap = '0;
    logic       multi_cap = 1'b0;
    logic [7:0] slot_cap = '0;

    patch_dump_7in8_decoder_checker_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic void clear_decoder_state();
        msg_count   = 0;
        prefix_msbs = '0;
        fault_seen  = '0;
        sum_acc     = '0;
        stored_acc  = '0;
        bank_cap    = '0;
        multi_cap   = 1'b0;
        slot_cap    = '0;
    endfunction

    function automatic void check_patch_byte(input int d, input logic [7:0] v);
        if (d == 0 && v != 8'h00)
            fault_seen[F_MAKER] = 1'b1;
        if (d == 1 && v != MAKER_HI)
            fault_seen[F_MAKER] = 1'b1;
        if (d == 2 && v != PRODUCT_ID)
            fault_seen[F_PRODUCT] = 1'b1;
        if (d == 4)
            bank_cap = v;
        if (d == 5)
            multi_cap = (v != 8'h00);
        if (d == 6)
            slot_cap = v;
        if (d >= int'(TAG_FIRST) && d < int'(TAG_FIRST) + 8
            && v != TAG_TEXT[8 * (7 - (d - int'(TAG_FIRST))) +: 8])
            fault_seen[F_TAG] = 1'b1;
        if (d >= int'(STORED_FIRST) && d < int'(STORED_FIRST) + 4)
            stored_acc = {stored_acc[23:0], v};
        if (d >= int'(SIZE_FIRST) && d < int'(SIZE_FIRST) + 4
            && v != SIZE_WORD[8 * (3 - (d - int'(SIZE_FIRST))) +: 8])
            fault_seen[F_SIZE] = 1'b1;
        if (d >= int'(SUM_FIRST) && d < int'(SUM_END))
            sum_acc = sum_acc + (32'(v) << (8 * (3 - ((d - int'(SUM_FIRST)) % 4))));
    endfunction

    function automatic void decode_request(input in_t req);
        out_t r;
        int pos;
        logic [7:0] v;
        logic got;
        r   = '0;
        v   = '0;
        got = 1'b0;
        if (msg_count < int'(PAYLOAD_LEN))
        begin
            pos = msg_count % 8;
            if (req.payload_byte[7])
                fault_seen[F_STATUS] = 1'b1;
            if (pos == 0)
                prefix_msbs = req.payload_byte[6:0];
            else
            begin
                v   = {prefix_msbs[7 - pos], req.payload_byte[6:0]};
                got = 1'b1;
                check_patch_byte((msg_count / 8) * 7 + pos - 1, v);
            end
        end
        if (msg_count < int'(COUNT_SAT))
            msg_count++;
        if (got || req.end_of_message)
        begin
            r.data_valid   = got;
            r.decoded_byte = v;
            if (req.end_of_message)
            begin
                r.done_res = 1'b1;
                if (msg_count != int'(PAYLOAD_LEN))
                    r.status = ST_LENGTH;
                else if (fault_seen[F_STATUS])
                    r.status = ST_STATBIT;
                else if (fault_seen[F_MAKER])
                    r.status = ST_MAKER;
                else if (fault_seen[F_PRODUCT])
                    r.status = ST_PRODUCT;
                else if (fault_seen[F_TAG])
                    r.status = ST_TAG;
                else if (fault_seen[F_SIZE])
                    r.status = ST_SIZE;
                else
                    r.status = ST_OK;
                if (r.status == ST_OK)
                begin
                    r.computed_checksum = 32'd0 - sum_acc;
                    r.file_checksum     = stored_acc;
                    r.checksum_ok       = (stored_acc == r.computed_checksum);
                    r.bank              = bank_cap;
                    r.multiple          = multi_cap;
                    r.slot              = slot_cap;
                end
                clear_decoder_state();
            end
            expected_results.insert(expected_results.size(), r);
        end
    endfunction

    always @(posedge clk)
        if (rst_n && byte_valid && !byte_stall)
            decode_request(byte_data);

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_REPORTS)
            $display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing pending", 32'(res_data.decoded_byte),
                                32'd0);
            else
            begin
                want = expected_results.pop_front();
                if (res_data.data_valid !== want.data_valid)
                    report_mismatch("data_valid", 32'(res_data.data_valid),
                                    32'(want.data_valid));
                if (res_data.decoded_byte !== want.decoded_byte)
                    report_mismatch("decoded_byte", 32'(res_data.decoded_byte),
                                    32'(want.decoded_byte));
                if (res_data.done_res !== want.done_res)
                    report_mismatch("done_res", 32'(res_data.done_res), 32'(want.done_res));
                if (res_data.status !== want.status)
                    report_mismatch("status", 32'(res_data.status), 32'(want.status));
                if (res_data.checksum_ok !== want.checksum_ok)
                    report_mismatch("checksum_ok", 32'(res_data.checksum_ok),
                                    32'(want.checksum_ok));
                if (res_data.bank !== want.bank)
                    report_mismatch("bank", 32'(res_data.bank), 32'(want.bank));
                if (res_data.multiple !== want.multiple)
                    report_mismatch("multiple", 32'(res_data.multiple), 32'(want.multiple));
                if (res_data.slot !== want.slot)
                    report_mismatch("slot", 32'(res_data.slot), 32'(want.slot));
                if (res_data.file_checksum !== want.file_checksum)
                    report_mismatch("file_checksum", res_data.file_checksum,
                                    want.file_checksum);
                if (res_data.computed_checksum !== want.computed_checksum)
                    report_mismatch("computed_checksum", res_data.computed_checksum,
                                    want.computed_checksum);
            end
        end
    end

    always @(posedge clk)
        res_stall <= hold_off || ($urandom_range(99) < stall_pct);

    initial
    begin
        forever
        begin
            @(hold_start);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    function automatic void set_idle(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        stall_pct     = receiver_pct;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= '{payload_byte: b, end_of_message: eom};
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
    endtask

    function automatic void make_patch(input logic sum_good);
        logic [31:0] total;
        logic [31:0] word;
        total = '0;
        foreach (patch_image[i])
            patch_image[i] = 8'($urandom);
        patch_image[0] = 8'h00;
        patch_image[1] = MAKER_HI;
        patch_image[2] = PRODUCT_ID;
        if ($urandom_range(1) == 0)
            patch_image[5] = 8'h00;
        for (int k = 0; k < 8; k++)
            patch_image[int'(TAG_FIRST) + k] = TAG_TEXT[8 * (7 - k) +: 8];
        for (int k = 0; k < 4; k++)
            patch_image[int'(SIZE_FIRST) + k] = SIZE_WORD[8 * (3 - k) +: 8];
        for (int w = 0; w < SUM_WORDS; w++)
        begin
            word = {patch_image[int'(SUM_FIRST) + 4 * w], patch_image[int'(SUM_FIRST) + 4 * w + 1],
                    patch_image[int'(SUM_FIRST) + 4 * w + 2],
                    patch_image[int'(SUM_FIRST) + 4 * w + 3]};
            total = total + word;
        end
        total = sum_good ? 32'd0 - total : $urandom;
        for (int k = 0; k < 4; k++)
            patch_image[int'(STORED_FIRST) + k] = total[8 * (3 - k) +: 8];
    endfunction

    function automatic void pack_patch();
        logic [7:0] prefix;
        wire_bytes.delete();
        for (int g = 0; g < PATCH_BYTES / 7; g++)
        begin
            prefix = '0;
            for (int j = 0; j < 7; j++)
                prefix[6 - j] = patch_image[g * 7 + j][7];
            wire_bytes.insert(wire_bytes.size(), prefix);
            for (int j = 0; j < 7; j++)
                wire_bytes.insert(wire_bytes.size(), {1'b0, patch_image[g * 7 + j][6:0]});
        end
    endfunction

    task automatic send_patch(input fault_t fault);
        int n;
        make_patch(fault != FAULT_SUM);
        case (fault)
            FAULT_MAKER:   n = $urandom_range(1);
            FAULT_PRODUCT: n = 2;
            FAULT_TAG:     n = int'(TAG_FIRST) + $urandom_range(7);
            FAULT_SIZE:    n = int'(SIZE_FIRST) + $urandom_range(3);
            default:       n = -1;
        endcase
        if (n >= 0)
            patch_image[n] = patch_image[n] ^ 8'($urandom_range(255, 1));
        pack_patch();
        case (fault)
            FAULT_STATBIT:
            begin
                n = $urandom_range(int'(PAYLOAD_LEN) - 1);
                wire_bytes[n] = wire_bytes[n] | 8'h80;
            end
            FAULT_LONG:
                repeat ($urandom_range(20, 1))
                    wire_bytes.insert(wire_bytes.size(), 8'($urandom));
            FAULT_SHORT:
            begin
                n = $urandom_range(100, 1);
                wire_bytes = wire_bytes[0:n - 1];
            end
            default: ;
        endcase
        foreach (wire_bytes[i])
            send_byte(wire_bytes[i], i == wire_bytes.size() - 1);
    endtask

    task automatic test_directed_bytes();
        set_idle(0, 0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h2A, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_clean_patch();
        set_idle(58, 0);
        send_patch(FAULT_NONE);
    endtask

    task automatic test_patch_faults();
        fault_t f;
        f = fault_t'($urandom_range(int'(FAULT_SIZE), int'(FAULT_SUM)));
        set_idle(0, 58);
        send_patch(f);
    endtask

    task automatic test_length();
        set_idle(9, 9);
        send_patch(FAULT_SHORT);
    endtask

    task automatic test_backpressure();
        set_idle(0, 0);
        -> hold_start;
        send_patch(FAULT_LONG);
    endtask

    task automatic test_noise();
        int len;
        for (int m = 0; m < 16; m++)
        begin
            case (m % 4)
                0: set_idle(0, 0);
                1: set_idle(58, 0);
                2: set_idle(0, 58);
                default: set_idle(9, 9);
            endcase
            len = $urandom_range(40, 1);
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom), i == len - 1);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_bytes();
        test_clean_patch();
        test_patch_faults();
        test_length();
        test_backpressure();
        test_noise();
        byte_valid <= 1'b0;
        set_idle(0, 0);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/p7d_pkg.sv
rtl/p7d_step.sv
rtl/patch_dump_7in8_decoder_checker_top.sv
test/tb.sv
